>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

   localparam int MAX_BLOCKS      = 256;
   localparam int PREFIX_BYTES    = 8;
   localparam int MIN_BLOCK_BYTES = 8;

   localparam int IDX_W     = $clog2(MAX_BLOCKS);
   localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
   localparam int BSIZE_W   = 16;
   localparam int RSIZE_W   = 21;
   localparam int DIVISOR_W = BSIZE_W + 1;
   localparam int CSR_W     = 21;
   localparam int CSR_IDX_W = 1;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 3;

   localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RECLAIM = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_USED  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_SMALL     = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_SIZE = 1'b1;

   localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RESET  = 16'd64;
   localparam logic [RSIZE_W-1:0] REGION_SIZE_RESET = 21'd16384;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [BSIZE_W-1:0] req_bytes;
      logic [IDX_W-1:0]   block_index;
      logic               is_null;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    granted_index;
      logic [CNT_W-1:0]    free_count;
   } rsp_word_type;

endpackage

>>> hw/rtl/fbpa_ram.sv
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/fbpa_div.sv
module fbpa_div #(
   parameter int DIVIDEND_W = 21,
   parameter int DIVISOR_W  = 17,
   localparam int STEP_W = $clog2(DIVIDEND_W + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
         step_ff <= STEP_W'(DIVIDEND_W);
      end else if (busy_ff) begin
         quo_ff  <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/fixed_block_pool_allocator.sv
// Channel   Direction  Handshake             Word
// req_      in         req_valid/req_stall   mode, req_bytes, block_index, is_null
// rsp_      out        rsp_valid/rsp_stall   status, granted_index, free_count
// csr_      in         csr_we                csr_index, csr_wdata
//
// Reserve, reclaim and no-op: one read-modify-write of the stack and used-bit memories,
// with the read on accept and the write in execute.
// Rebuild: the 21-step divider, then one stack write per block over all MAX_BLOCKS
// entries, which also clears the used bits.
// Reset: synchronous, input stalled; no clearing pass, each rebuild sweeps the memories.
// A stalled result holds in the output register; the next word waits in execute (a rebuild in finish).
`include "assert_macros.svh"

module fixed_block_pool_allocator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  fbpa_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output fbpa_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_we,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fbpa_pkg::CSR_W-1:0]             csr_wdata
);

   localparam int IDX_W = fbpa_pkg::IDX_W;
   localparam int CNT_W = fbpa_pkg::CNT_W;

   fbpa_pkg::state_type    state_ff;
   fbpa_pkg::state_type    state_in;
   fbpa_pkg::req_word_type item_ff;
   fbpa_pkg::rsp_word_type rsp_word_ff;
   fbpa_pkg::rsp_word_type rsp_word_in;
   fbpa_pkg::rsp_word_type exec_word;

   logic [fbpa_pkg::BSIZE_W-1:0] block_size_ff;
   logic [fbpa_pkg::RSIZE_W-1:0] region_size_ff;
   logic [fbpa_pkg::BSIZE_W-1:0] latched_ff;
   logic [CNT_W-1:0]             stack_top_ff;
   logic [CNT_W-1:0]             stack_top_in;
   logic [CNT_W-1:0]             pool_blocks_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [IDX_W-1:0]             sweep_ff;
   logic                         rsp_valid_ff;

   logic                         accept;
   logic                         slot_free;
   logic                         rsp_load;
   logic                         commit;
   logic                         div_start;
   logic                         div_done;
   logic [fbpa_pkg::RSIZE_W-1:0] quotient;
   logic                         sweep_last;
   logic [CNT_W-1:0]             top_dec;

   logic                         stk_push;
   logic                         use_set;
   logic                         use_clr;
   logic                         rebuild_go;

   logic                         stk_wr_en;
   logic [IDX_W-1:0]             stk_wr_addr;
   logic [IDX_W-1:0]             stk_wr_data;
   logic [IDX_W-1:0]             stk_rd_data;
   logic                         use_wr_en;
   logic [IDX_W-1:0]             use_wr_addr;
   logic [0:0]                   use_wr_data;
   logic [0:0]                   use_rd_data;

   assign accept     = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign top_dec    = stack_top_ff - CNT_W'(1);
   assign sweep_last = (state_ff == fbpa_pkg::ST_SWEEP)
                       && (sweep_ff == IDX_W'(fbpa_pkg::MAX_BLOCKS - 1));

   fbpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (fbpa_pkg::MAX_BLOCKS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (accept),
      .rd_addr (top_dec[IDX_W-1:0]),
      .rd_data (stk_rd_data)
   );

   fbpa_ram #(
      .WIDTH (1),
      .DEPTH (fbpa_pkg::MAX_BLOCKS)
   ) u_used (
      .clock   (clock),
      .wr_en   (use_wr_en),
      .wr_addr (use_wr_addr),
      .wr_data (use_wr_data),
      .rd_en   (accept),
      .rd_addr (req_word.block_index),
      .rd_data (use_rd_data)
   );

   fbpa_div #(
      .DIVIDEND_W (fbpa_pkg::RSIZE_W),
      .DIVISOR_W  (fbpa_pkg::DIVISOR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (region_size_ff),
      .divisor  (fbpa_pkg::DIVISOR_W'(block_size_ff)
                 + fbpa_pkg::DIVISOR_W'(fbpa_pkg::PREFIX_BYTES)),
      .done     (div_done),
      .quotient (quotient)
   );

   // decode the item in its execute cycle
   always_comb begin
      exec_word.status        = fbpa_pkg::STAT_OK;
      exec_word.granted_index = '0;
      stack_top_in            = stack_top_ff;
      stk_push                = 1'b0;
      use_set                 = 1'b0;
      use_clr                 = 1'b0;
      rebuild_go              = 1'b0;
      case (item_ff.mode)
         fbpa_pkg::MODE_RESERVE: begin
            if (stack_top_ff == '0) begin
               exec_word.status = fbpa_pkg::STAT_EMPTY;
            end else if (item_ff.req_bytes > latched_ff) begin
               exec_word.status = fbpa_pkg::STAT_TOO_LARGE;
            end else begin
               exec_word.granted_index = stk_rd_data;
               stack_top_in            = top_dec;
               use_set                 = 1'b1;
            end
         end
         fbpa_pkg::MODE_RECLAIM: begin
            if (item_ff.is_null) begin
               exec_word.status = fbpa_pkg::STAT_OK;
            end else if (CNT_W'(item_ff.block_index) >= pool_blocks_ff) begin
               exec_word.status = fbpa_pkg::STAT_RANGE;
            end else if (!use_rd_data[0]) begin
               exec_word.status = fbpa_pkg::STAT_NOT_USED;
            end else begin
               use_clr = 1'b1;
               if (stack_top_ff < CNT_W'(fbpa_pkg::MAX_BLOCKS)) begin
                  stk_push     = 1'b1;
                  stack_top_in = stack_top_ff + CNT_W'(1);
               end
            end
         end
         fbpa_pkg::MODE_REBUILD: begin
            if (block_size_ff < fbpa_pkg::BSIZE_W'(fbpa_pkg::MIN_BLOCK_BYTES)) begin
               exec_word.status = fbpa_pkg::STAT_SMALL;
            end else begin
               rebuild_go = 1'b1;
            end
         end
         default: begin
            exec_word.status = fbpa_pkg::STAT_OK;
         end
      endcase
      exec_word.free_count = stack_top_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbpa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = fbpa_pkg::ST_EXEC;
            end
         end
         fbpa_pkg::ST_EXEC: begin
            if (rebuild_go) begin
               state_in = fbpa_pkg::ST_DIV;
            end else if (slot_free) begin
               state_in = fbpa_pkg::ST_IDLE;
            end
         end
         fbpa_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = fbpa_pkg::ST_SWEEP;
            end
         end
         fbpa_pkg::ST_SWEEP: begin
            if (sweep_last) begin
               state_in = fbpa_pkg::ST_FINISH;
            end
         end
         fbpa_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = fbpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbpa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_load    = 1'b0;
      rsp_word_in = exec_word;
      commit      = 1'b0;
      div_start   = 1'b0;
      stk_wr_en   = 1'b0;
      stk_wr_addr = stack_top_ff[IDX_W-1:0];
      stk_wr_data = item_ff.block_index;
      use_wr_en   = 1'b0;
      use_wr_addr = use_set ? stk_rd_data : item_ff.block_index;
      use_wr_data = use_set;
      case (state_ff)
         fbpa_pkg::ST_IDLE: begin
            req_stall = reset;
         end
         fbpa_pkg::ST_EXEC: begin
            if (rebuild_go) begin
               div_start = 1'b1;
            end else if (slot_free) begin
               rsp_load  = 1'b1;
               commit    = 1'b1;
               stk_wr_en = stk_push;
               use_wr_en = use_set || use_clr;
            end
         end
         fbpa_pkg::ST_SWEEP: begin
            stk_wr_en   = 1'b1;
            stk_wr_addr = sweep_ff;
            stk_wr_data = sweep_ff;
            use_wr_en   = 1'b1;
            use_wr_addr = sweep_ff;
            use_wr_data = 1'b0;
         end
         fbpa_pkg::ST_FINISH: begin
            rsp_word_in.status        = fbpa_pkg::STAT_OK;
            rsp_word_in.granted_index = '0;
            rsp_word_in.free_count    = stack_top_ff;
            rsp_load                  = slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fbpa_pkg::ST_IDLE;
         block_size_ff  <= fbpa_pkg::BLOCK_SIZE_RESET;
         region_size_ff <= fbpa_pkg::REGION_SIZE_RESET;
         latched_ff     <= fbpa_pkg::BLOCK_SIZE_RESET;
         stack_top_ff   <= '0;
         pool_blocks_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == fbpa_pkg::CSR_BLOCK_SIZE) begin
            block_size_ff <= csr_wdata[fbpa_pkg::BSIZE_W-1:0];
         end
         if (csr_we && csr_index == fbpa_pkg::CSR_REGION_SIZE) begin
            region_size_ff <= csr_wdata[fbpa_pkg::RSIZE_W-1:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (div_start) begin
            latched_ff <= block_size_ff;
         end
         if (commit) begin
            stack_top_ff <= stack_top_in;
         end else if (sweep_last) begin
            stack_top_ff   <= count_ff;
            pool_blocks_ff <= count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_word;
      end
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
      if (div_done) begin
         count_ff <= (quotient > fbpa_pkg::RSIZE_W'(fbpa_pkg::MAX_BLOCKS))
                     ? CNT_W'(fbpa_pkg::MAX_BLOCKS) : quotient[CNT_W-1:0];
         sweep_ff <= '0;
      end else if (state_ff == fbpa_pkg::ST_SWEEP) begin
         sweep_ff <= sweep_ff + IDX_W'(1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `ASSERT_SAME(a_top_in_pool, clock, reset, 1'b1, stack_top_ff <= pool_blocks_ff)
   `ASSERT_SAME(a_grant_in_pool, clock, reset, (state_ff == fbpa_pkg::ST_EXEC) && use_set,
      CNT_W'(stk_rd_data) < pool_blocks_ff)
   `ASSERT_NEXT(a_div_to_sweep, clock, reset, state_ff == fbpa_pkg::ST_DIV,
      (state_ff == fbpa_pkg::ST_DIV) || (state_ff == fbpa_pkg::ST_SWEEP))
   `ASSERT_NEXT(a_sweep_sets_top, clock, reset, sweep_last,
      (stack_top_ff == count_ff) && (pool_blocks_ff == count_ff))

endmodule

>>> tb/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 100ps

import fbpa_pkg::*;

class block_pool_checker;
   bit [IDX_W-1:0]   free_stack [MAX_BLOCKS];
   bit [CNT_W-1:0]   stack_top;
   bit               used_bits [MAX_BLOCKS];
   bit [CNT_W-1:0]   pool_blocks;
   bit [BSIZE_W-1:0] latched_size;
   bit [BSIZE_W-1:0] block_size;
   bit [RSIZE_W-1:0] region_size;
   rsp_word_type     expected_words [$];
   int               mismatches;

   function new();
      foreach (used_bits[i]) begin
         used_bits[i]  = 1'b0;
         free_stack[i] = '0;
      end
      stack_top    = '0;
      pool_blocks  = '0;
      latched_size = BLOCK_SIZE_RESET;
      block_size   = BLOCK_SIZE_RESET;
      region_size  = REGION_SIZE_RESET;
      mismatches   = 0;
   endfunction

   function void write_config(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] data);
      if (index == CSR_BLOCK_SIZE) begin
         block_size = data[BSIZE_W-1:0];
      end else begin
         region_size = data[RSIZE_W-1:0];
      end
   endfunction

   function void refill_pool();
      int count;
      count = int'(region_size) / (int'(block_size) + PREFIX_BYTES);
      if (count > MAX_BLOCKS) begin
         count = MAX_BLOCKS;
      end
      latched_size = block_size;
      foreach (used_bits[i]) begin
         used_bits[i] = 1'b0;
      end
      for (int i = 0; i < count; i++) begin
         free_stack[i] = IDX_W'(i);
      end
      stack_top   = CNT_W'(count);
      pool_blocks = CNT_W'(count);
   endfunction

   function void note_request(req_word_type w);
      rsp_word_type   r;
      bit [IDX_W-1:0] b;
      r = '0;
      r.status = STAT_OK;
      case (w.mode)
         MODE_RESERVE: begin
            if (stack_top == 0) begin
               r.status = STAT_EMPTY;
            end else if (w.req_bytes > latched_size) begin
               r.status = STAT_TOO_LARGE;
            end else begin
               stack_top = stack_top - 1'b1;
               b = free_stack[stack_top[IDX_W-1:0]];
               used_bits[b] = 1'b1;
               r.granted_index = b;
            end
         end
         MODE_RECLAIM: begin
            if (w.is_null) begin
               r.status = STAT_OK;
            end else if (w.block_index >= pool_blocks) begin
               r.status = STAT_RANGE;
            end else if (!used_bits[w.block_index]) begin
               r.status = STAT_NOT_USED;
            end else begin
               used_bits[w.block_index] = 1'b0;
               if (stack_top < MAX_BLOCKS) begin
                  free_stack[stack_top[IDX_W-1:0]] = w.block_index;
                  stack_top = stack_top + 1'b1;
               end
            end
         end
         MODE_REBUILD: begin
            if (block_size < MIN_BLOCK_BYTES) begin
               r.status = STAT_SMALL;
            end else begin
               refill_pool();
            end
         end
         default: ;
      endcase
      r.free_count = stack_top;
      expected_words.push_back(r);
   endfunction

   task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task check_response(rsp_word_type got);
      rsp_word_type want;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("word with nothing expected, status %0d", got.status));
         return;
      end
      want = expected_words.pop_front();
      if (got.status !== want.status) begin
         report_mismatch($sformatf("status expected %0d got %0d", want.status, got.status));
      end
      if (got.granted_index !== want.granted_index) begin
         report_mismatch($sformatf("granted_index expected %0d got %0d",
                                   want.granted_index, got.granted_index));
      end
      if (got.free_count !== want.free_count) begin
         report_mismatch($sformatf("free_count expected %0d got %0d",
                                   want.free_count, got.free_count));
      end
   endtask
endclass

module fixed_block_pool_allocator_tb;
   localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 2 + 21 + MAX_BLOCKS + 16;
   localparam int RSIZE_MAX    = (1 << RSIZE_W) - 1;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_word_type         req_word;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_word_type         rsp_word;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   block_pool_checker pool_model = new();
   int unsigned       cycles = 0;
   int                rx_hold = 0;
   int                rx_wait = 0;
   bit                idle_gaps = 1'b1;

   fixed_block_pool_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("fixed_block_pool_allocator regression: fail");
      $finish;
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            pool_model.check_response(rsp_word);
            rx_wait = idle_gaps ? $urandom_range(0, 3) : 0;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_word_type mk_word(logic [MODE_W-1:0] mode, logic [BSIZE_W-1:0] bytes,
                                            logic [IDX_W-1:0] index, logic nul);
      req_word_type w;
      w.mode        = mode;
      w.req_bytes   = bytes;
      w.block_index = index;
      w.is_null     = nul;
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      int gap;
      gap = idle_gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      pool_model.note_request(w);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pool_model.expected_words.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_pool(logic [CSR_W-1:0] bs_word, logic [CSR_W-1:0] rs_word);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_BLOCK_SIZE;
      csr_wdata <= bs_word;
      pool_model.write_config(CSR_BLOCK_SIZE, bs_word);
      @(posedge clock);
      csr_index <= CSR_REGION_SIZE;
      csr_wdata <= rs_word;
      pool_model.write_config(CSR_REGION_SIZE, rs_word);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_word_type next_random_word();
      req_word_type w;
      int           pick;
      int           held [$];
      w = req_word_type'($urandom);
      pick = $urandom_range(0, 99);
      for (int i = 0; i < pool_model.pool_blocks; i++) begin
         if (pool_model.used_bits[i]) begin
            held.push_back(i);
         end
      end
      if (pick >= 45 && pick < 80 && held.size() > 0) begin
         w.mode        = MODE_RECLAIM;
         w.is_null     = 1'b0;
         w.block_index = IDX_W'(held[$urandom_range(0, held.size() - 1)]);
      end else if (pick < 80) begin
         w.mode = MODE_RESERVE;
         if (pick >= 40 && pick < 45) begin
            w.req_bytes = BSIZE_W'($urandom);
         end else begin
            w.req_bytes = BSIZE_W'($urandom_range(0, pool_model.latched_size));
         end
      end else if (pick < 88) begin
         w.mode    = MODE_RECLAIM;
         w.is_null = 1'b0;
      end else if (pick < 93) begin
         w.mode    = MODE_RECLAIM;
         w.is_null = 1'b1;
      end else if (pick < 97) begin
         w.mode = MODE_NOP;
      end else begin
         w.mode = MODE_REBUILD;
      end
      return w;
   endfunction

   task automatic random_phase(int phase, int items);
      int               bs;
      int               count;
      int               rs;
      logic [CSR_W-1:0] bs_word;
      case ($urandom_range(0, 9))
         0:       bs = $urandom_range(0, MIN_BLOCK_BYTES - 1);
         1:       bs = (1 << BSIZE_W) - 1;
         2:       bs = MIN_BLOCK_BYTES;
         default: bs = $urandom_range(MIN_BLOCK_BYTES, 600);
      endcase
      case ($urandom_range(0, 9))
         0:       count = 0;
         1:       count = MAX_BLOCKS;
         default: count = $urandom_range(1, 12);
      endcase
      rs = count * (bs + PREFIX_BYTES) + $urandom_range(0, bs + PREFIX_BYTES - 1);
      if (rs > RSIZE_MAX) begin
         rs = RSIZE_MAX;
      end
      bs_word = '0;
      bs_word[BSIZE_W-1:0] = BSIZE_W'(bs);
      bs_word[CSR_W-1:BSIZE_W] = ($urandom_range(0, 1) == 1) ? (CSR_W - BSIZE_W)'($urandom) : '0;
      set_pool(bs_word, CSR_W'(rs));
      idle_gaps = ($urandom_range(0, 3) != 0);
      send_word(mk_word(MODE_REBUILD, BSIZE_W'($urandom), IDX_W'($urandom), 1'($urandom)));
      if (phase == 3) begin
         rx_hold = 400;
      end
      for (int n = 0; n < items; n++) begin
         if (phase == 5 && n == 10) begin
            wait_drained();
         end
         send_word(next_random_word());
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_word(mk_word(MODE_RESERVE, '0, '0, 1'b0));
      send_word(mk_word(MODE_RECLAIM, '0, 8'd255, 1'b1));
      send_word(mk_word(MODE_RECLAIM, '0, 8'd0, 1'b0));
      send_word(mk_word(MODE_NOP, 16'hFFFF, 8'hFF, 1'b1));
      send_word(mk_word(MODE_REBUILD, '0, '0, 1'b0));
      send_word(mk_word(MODE_RESERVE, 16'd64, '0, 1'b0));
      send_word(mk_word(MODE_RESERVE, 16'd65, '0, 1'b0));
      send_word(mk_word(MODE_RESERVE, 16'hFFFF, '0, 1'b0));
      send_word(mk_word(MODE_RECLAIM, '0, 8'd226, 1'b0));
      send_word(mk_word(MODE_RECLAIM, '0, 8'd226, 1'b0));
      send_word(mk_word(MODE_RECLAIM, '0, 8'd227, 1'b0));
      send_word(mk_word(MODE_RECLAIM, '0, 8'd255, 1'b0));
      send_word(mk_word(MODE_RECLAIM, '0, 8'd0, 1'b0));
      send_word(mk_word(MODE_RESERVE, '0, '0, 1'b0));

      set_pool(CSR_W'(7), CSR_W'(16384));
      send_word(mk_word(MODE_REBUILD, '0, '0, 1'b0));
      send_word(mk_word(MODE_RESERVE, 16'd1, '0, 1'b0));
      set_pool('0, '0);
      send_word(mk_word(MODE_REBUILD, '0, '0, 1'b0));
      set_pool(CSR_W'(MIN_BLOCK_BYTES), '0);
      send_word(mk_word(MODE_REBUILD, '0, '0, 1'b0));
      send_word(mk_word(MODE_RESERVE, '0, '0, 1'b0));
      send_word(mk_word(MODE_RECLAIM, '0, 8'd0, 1'b0));
      set_pool({{(CSR_W - BSIZE_W){1'b1}}, 16'hFFFF}, CSR_W'(RSIZE_MAX));
      send_word(mk_word(MODE_REBUILD, '0, '0, 1'b0));
      send_word(mk_word(MODE_RESERVE, 16'hFFFF, '0, 1'b0));
      set_pool(CSR_W'(MIN_BLOCK_BYTES), CSR_W'(1048576));
      send_word(mk_word(MODE_REBUILD, '0, '0, 1'b0));
      send_word(mk_word(MODE_RESERVE, 16'd8, '0, 1'b0));
      send_word(mk_word(MODE_RECLAIM, '0, 8'd255, 1'b0));
      set_pool(CSR_W'(16), CSR_W'(24));
      send_word(mk_word(MODE_REBUILD, '0, '0, 1'b0));
      send_word(mk_word(MODE_RESERVE, 16'd16, '0, 1'b0));
      send_word(mk_word(MODE_RESERVE, 16'd1, '0, 1'b0));

      for (int p = 0; p < 14; p++) begin
         random_phase(p, 30);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pool_model.mismatches == 0 && pool_model.expected_words.size() == 0) begin
         $display("fixed_block_pool_allocator regression: pass");
      end else begin
         $display("fixed_block_pool_allocator regression: fail");
      end
      $finish;
   end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fbpa_div.sv
hw/rtl/fixed_block_pool_allocator.sv
tb/fixed_block_pool_allocator_tb.sv
